### hdl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// Date string difference package
// Shared widths, the date record passed from parser to calculator, status
// codes and the Gregorian month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

   // Field widths of a parsed date after validation.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DAYS_W  = 6;
   localparam int MLEN_W  = 5;

   // Years below 100, as two-digit years give, are taken as years of this century.
   localparam logic [YEAR_W-1:0] YEAR_SHORT_LIMIT = YEAR_W'(100);
   localparam logic [YEAR_W-1:0] YEAR_SHORT_BASE  = YEAR_W'(2000);

   // Depth of the date queue; a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_START_BAD = 2'd1;
   localparam status_type STATUS_END_BAD   = 2'd2;
   localparam status_type STATUS_ORDER     = 2'd3;

   // One parsed date string, as handed from the parser to the calculator.
   // The year is already adjusted for two-digit years.
   typedef struct packed {
      logic              ok;
      logic              leap;
      logic [DAY_W-1:0]  day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0] year;
   } date_rec_type;

   // Days in a month, with February lengthened in a leap year.
   function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [MLEN_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### hdl/date_string_difference.sv
// A result item becomes valid once the end string's record has passed the date queue and the result register.
// Throughput: one character item per cycle; the parser takes a character every cycle while the
// two-entry date queue has room, and the calculator drains one record per cycle.
// The result register frees the queue unless a result item is stalled on rsp_ready.
// Reset (synchronous, active high) returns the parser to the start string's day field,
// empties the queue and drops any pending result item.
// ----------------------------------------------------------------------------
// Date string difference
// Parses a start and an end dd/mm/yy(yy) string streamed one character per
// item and returns the status and year/month/day difference between them.
// ----------------------------------------------------------------------------
`default_nettype none

module date_string_difference (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_terminator,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [dsd_pkg::YEAR_W-1:0]         rsp_years,
   output logic [dsd_pkg::MONTH_W-1:0]        rsp_months,
   output logic signed [dsd_pkg::DAYS_W-1:0]  rsp_days
);
   import dsd_pkg::*;

   logic         push;
   date_rec_type push_rec;
   logic         queue_full;
   logic         q_not_empty;
   date_rec_type q_rec;
   logic         q_pop;

   // Character parser and validator.
   dsd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_terminator (req_terminator),
      .queue_full     (queue_full),
      .push           (push),
      .push_rec       (push_rec)
   );

   // Queue of parsed dates.
   dsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .not_empty (q_not_empty),
      .head_rec  (q_rec),
      .pop       (q_pop)
   );

   // Difference calculator and result register.
   dsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rec       (q_rec),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_years   (rsp_years),
      .rsp_months  (rsp_months),
      .rsp_days    (rsp_days)
   );

endmodule

`default_nettype wire

### hdl/dsd_front.sv
// ----------------------------------------------------------------------------
// Date string parser
// Accepts one character item per cycle while the queue has room, tracks the
// dd/mm/yy(yy) shape and the field values, and on a terminator item
// validates the date and pushes one date record into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_ch,
   input  wire logic                  req_terminator,
   input  wire logic                  queue_full,
   output logic                       push,
   output dsd_pkg::date_rec_type      push_rec
);
   import dsd_pkg::*;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      FLD_DAY   = 3'b001,
      FLD_MONTH = 3'b010,
      FLD_YEAR  = 3'b100
   } field_type;

   field_type         field_ff, field_in;
   logic [2:0]        len_ff, len_in;
   logic [6:0]        day_ff, day_in;
   logic [6:0]        month_ff, month_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic              stopped_ff, stopped_in;
   logic              bad_ff, bad_in;
   logic [3:0]        tens_ff, tens_in;
   logic [3:0]        ones_ff, ones_in;
   logic [1:0]        hund_ff, hund_in;

   logic              accept;
   logic              is_digit;
   logic              is_slash;
   logic [3:0]        digit;
   logic              leap;
   logic [MLEN_W-1:0] mlen;
   logic              month_ok;
   logic              day_ok;
   logic              date_ok;
   logic [YEAR_W-1:0] year_adj;

   // An item is taken whenever the queue has room for a record.
   assign req_ready = ~queue_full;
   assign accept    = req_valid & req_ready;

   assign is_digit = (req_ch >= CHAR_ZERO) && (req_ch <= CHAR_NINE);
   assign is_slash = (req_ch == CHAR_SLASH);
   assign digit    = req_ch[3:0];

   // Next-state logic for the character parser.
   always_comb begin
      field_in   = field_ff;
      len_in     = len_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      stopped_in = stopped_ff;
      bad_in     = bad_ff;
      tens_in    = tens_ff;
      ones_in    = ones_ff;
      hund_in    = hund_ff;
      if (accept) begin
         if (req_terminator) begin
            field_in   = FLD_DAY;
            len_in     = 3'd0;
            day_in     = 7'd0;
            month_in   = 7'd0;
            year_in    = '0;
            stopped_in = 1'b0;
            bad_in     = 1'b0;
            tens_in    = 4'd0;
            ones_in    = 4'd0;
            hund_in    = 2'd0;
         end else if (!bad_ff) begin
            case (field_ff)
               FLD_DAY, FLD_MONTH: begin
                  if (is_slash) begin
                     if (len_ff == 3'd1 || len_ff == 3'd2) begin
                        field_in = (field_ff == FLD_DAY) ? FLD_MONTH : FLD_YEAR;
                        len_in   = 3'd0;
                     end else begin
                        bad_in = 1'b1;
                     end
                  end else if (is_digit && len_ff < 3'd2) begin
                     if (field_ff == FLD_DAY) begin
                        day_in = 7'((day_ff << 3) + (day_ff << 1)) + {3'd0, digit};
                     end else begin
                        month_in = 7'((month_ff << 3) + (month_ff << 1)) + {3'd0, digit};
                     end
                     len_in = 3'(len_ff + 3'd1);
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               FLD_YEAR: begin
                  if ((!is_digit && !is_slash) || len_ff >= 3'd4) begin
                     bad_in = 1'b1;
                  end else begin
                     len_in = 3'(len_ff + 3'd1);
                     if (is_slash) begin
                        stopped_in = 1'b1;
                     end else if (!stopped_ff) begin
                        year_in = YEAR_W'((year_ff << 3) + (year_ff << 1))
                                  + {{(YEAR_W-4){1'b0}}, digit};
                        // Keep the last two digits and the hundreds mod 4
                        // for the leap-year rule.
                        hund_in = 2'({hund_ff[0], 1'b0} + tens_ff[1:0]);
                        tens_in = ones_ff;
                        ones_in = digit;
                     end
                  end
               end
               default: begin
                  field_in = FLD_DAY;
               end
            endcase
         end
      end
   end

   // Leap rule on the raw year value from its last two digits and hundreds.
   always_comb begin
      if (tens_ff == 4'd0 && ones_ff == 4'd0) begin
         leap = (hund_ff == 2'd0);
      end else begin
         leap = (2'({tens_ff[0], 1'b0} + ones_ff[1:0]) == 2'd0);
      end
   end

   // Validation: month range, then day against the month, then year.
   assign mlen     = month_length(month_ff[MONTH_W-1:0], leap);
   assign month_ok = (month_ff >= 7'd1) && (month_ff <= 7'd12);
   assign day_ok   = (day_ff != 7'd0) && (day_ff <= {2'd0, mlen});
   assign date_ok  = !bad_ff && (field_ff == FLD_YEAR) &&
                     (len_ff == 3'd2 || len_ff == 3'd4) &&
                     month_ok && day_ok && (year_ff != '0);
   assign year_adj = (year_ff < YEAR_SHORT_LIMIT) ? YEAR_W'(year_ff + YEAR_SHORT_BASE)
                                                  : year_ff;

   // A terminator item closes the string and hands its record on.
   assign push           = accept & req_terminator;
   assign push_rec.ok    = date_ok;
   assign push_rec.leap  = leap;
   assign push_rec.day   = day_ff[DAY_W-1:0];
   assign push_rec.month = month_ff[MONTH_W-1:0];
   assign push_rec.year  = year_adj;

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff   <= FLD_DAY;
         len_ff     <= 3'd0;
         day_ff     <= 7'd0;
         month_ff   <= 7'd0;
         year_ff    <= '0;
         stopped_ff <= 1'b0;
         bad_ff     <= 1'b0;
         tens_ff    <= 4'd0;
         ones_ff    <= 4'd0;
         hund_ff    <= 2'd0;
      end else begin
         field_ff   <= field_in;
         len_ff     <= len_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         stopped_ff <= stopped_in;
         bad_ff     <= bad_in;
         tens_ff    <= tens_in;
         ones_ff    <= ones_in;
         hund_ff    <= hund_in;
      end
   end

   // A bad shape sticks until the string's terminator item.
   assert property (@(posedge clock) disable iff (reset)
      bad_ff && !(accept && req_terminator) |=> bad_ff)
      else $error("format error flag dropped before the terminator item");

endmodule

`default_nettype wire

### hdl/dsd_queue.sv
// ----------------------------------------------------------------------------
// Date record queue
// Short first-in first-out queue of parsed date records between the parser
// and the difference calculator.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire dsd_pkg::date_rec_type push_rec,
   output logic                       full,
   output logic                       not_empty,
   output dsd_pkg::date_rec_type      head_rec,
   input  wire logic                  pop
);
   import dsd_pkg::*;

   date_rec_type          store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_rec  = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = (QUEUE_AW+1)'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = (QUEUE_AW+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("date queue holds more records than its depth");

endmodule

`default_nettype wire

### hdl/dsd_back.sv
// ----------------------------------------------------------------------------
// Date difference calculator
// Takes date records from the queue in start/end pairs, keeps the start
// date, and computes status and the year/month/day difference into the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_not_empty,
   input  wire dsd_pkg::date_rec_type         q_rec,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [dsd_pkg::YEAR_W-1:0]         rsp_years,
   output logic [dsd_pkg::MONTH_W-1:0]        rsp_months,
   output logic signed [dsd_pkg::DAYS_W-1:0]  rsp_days
);
   import dsd_pkg::*;

   logic                     on_end_ff, on_end_in;
   logic                     start_ok_ff;
   logic [DAY_W-1:0]         start_day_ff;
   logic [MONTH_W-1:0]       start_month_ff;
   logic [YEAR_W-1:0]        start_year_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic [YEAR_W-1:0]        years_ff, years_in;
   logic [MONTH_W-1:0]       months_ff, months_in;
   logic signed [DAYS_W-1:0] days_ff, days_in;

   logic                     can_take;
   logic                     after;
   logic [YEAR_W-1:0]        dy0;
   logic signed [4:0]        dm0;
   logic signed [4:0]        dm1;
   logic signed [4:0]        dm2;
   logic signed [DAYS_W-1:0] dd0;
   logic signed [DAYS_W-1:0] dd1;
   logic                     borrow_y;
   logic [MONTH_W-1:0]       prev_month;
   logic [MLEN_W-1:0]        prev_len;

   // A start record is always taken; an end record needs the result slot.
   assign can_take = !on_end_ff || !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_not_empty && can_take;

   // Start after end, compared year first, then month, then day.
   assign after = (start_year_ff > q_rec.year) ||
                  ((start_year_ff == q_rec.year) &&
                   ((start_month_ff > q_rec.month) ||
                    ((start_month_ff == q_rec.month) && (start_day_ff > q_rec.day))));

   // Raw differences, then the month and year borrows.
   assign dy0 = q_rec.year - start_year_ff;
   assign dm0 = $signed({1'b0, q_rec.month}) - $signed({1'b0, start_month_ff});
   assign dd0 = $signed({1'b0, q_rec.day}) - $signed({1'b0, start_day_ff});
   assign borrow_y = (dm0 < 0) || ((dm0 == 0) && (dd0 < 0));
   assign dm1 = borrow_y ? 5'(dm0 + 5'sd12) : dm0;

   // Days are borrowed from the month before the end month.
   assign prev_month = (q_rec.month == 4'd1) ? 4'd12 : MONTH_W'(q_rec.month - 1'b1);
   assign prev_len   = month_length(prev_month, q_rec.leap);

   always_comb begin
      if (dd0 < 0) begin
         dm2 = 5'(dm1 - 5'sd1);
         dd1 = $signed({1'b0, prev_len}) - $signed({1'b0, start_day_ff})
               + $signed({1'b0, q_rec.day});
      end else begin
         dm2 = dm1;
         dd1 = dd0;
      end
   end

   // Start capture and result register next state.
   always_comb begin
      on_end_in    = on_end_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      status_in    = status_ff;
      years_in     = years_ff;
      months_in    = months_ff;
      days_in      = days_ff;
      if (q_pop && on_end_ff) begin
         on_end_in    = 1'b0;
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         years_in     = '0;
         months_in    = '0;
         days_in      = '0;
         if (!start_ok_ff) begin
            status_in = STATUS_START_BAD;
         end else if (!q_rec.ok) begin
            status_in = STATUS_END_BAD;
         end else if (after) begin
            status_in = STATUS_ORDER;
         end else begin
            years_in  = YEAR_W'(dy0 - {{(YEAR_W-1){1'b0}}, borrow_y});
            months_in = dm2[MONTH_W-1:0];
            days_in   = dd1;
         end
      end else if (q_pop) begin
         on_end_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_end_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ok_ff  <= 1'b0;
      end else begin
         on_end_ff    <= on_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop && !on_end_ff) begin
            start_ok_ff <= q_rec.ok;
         end
      end
   end

   // Start date and result payload.
   always_ff @(posedge clock) begin
      if (q_pop && !on_end_ff) begin
         start_day_ff   <= q_rec.day;
         start_month_ff <= q_rec.month;
         start_year_ff  <= q_rec.year;
      end
      status_ff <= status_in;
      years_ff  <= years_in;
      months_ff <= months_in;
      days_ff   <= days_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_years  = years_ff;
   assign rsp_months = months_ff;
   assign rsp_days   = days_ff;

   assert property (@(posedge clock) disable iff (reset)
      q_pop && on_end_ff |=> rsp_valid_ff)
      else $error("end record taken without a result item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != STATUS_OK) |->
         (years_ff == '0) && (months_ff == '0) && (days_ff == '0))
      else $error("failed result item carries a nonzero difference");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_OK) |->
         (months_ff <= 4'd11) && (days_ff >= -6'sd2))
      else $error("month or day difference out of range");

endmodule

`default_nettype wire

### tb/date_string_difference_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Date string difference testbench
// Streams pairs of date strings into the block, one character item at a time,
// and checks every result item against a cycle-free model of the parser and
// the difference calculation. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module date_string_difference_tb;

   import dsd_pkg::*;

   localparam logic [7:0] SLASH_CH = 8'h2F;
   localparam logic [7:0] DIGIT_0  = 8'h30;
   localparam logic [7:0] DIGIT_9  = 8'h39;

   localparam int RANDOM_CHARS = 750;
   localparam int RANDOM_PAIRS = 15;

   // One result item as the block presents it.
   typedef struct packed {
      status_type                 status;
      logic [YEAR_W-1:0]          years;
      logic [MONTH_W-1:0]         months;
      logic signed [DAYS_W-1:0]   days;
   } date_diff_type;

   // Tracks the parse of the current string and queues the difference each
   // end string is expected to produce.
   class date_diff_tracker;
      bit            on_end;
      bit [1:0]      field_num;
      bit [2:0]      field_len;
      bit [6:0]      day_acc;
      bit [6:0]      month_acc;
      bit [13:0]     year_acc;
      bit            year_cut;
      bit            shape_bad;
      bit [6:0]      start_day;
      bit [6:0]      start_month;
      bit [13:0]     start_year;
      bit            start_good;
      date_diff_type pending_diffs[$];
      int            error_count;

      function void clear_fields();
         field_num = 0;
         field_len = 0;
         day_acc   = 0;
         month_acc = 0;
         year_acc  = 0;
         year_cut  = 0;
         shape_bad = 0;
      endfunction

      // Gregorian month length; the leap rule is applied to the year as given.
      static function int month_len(int m, int y);
         bit leap;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function bit fields_valid();
         if (shape_bad || field_num != 2) return 0;
         if (field_len != 2 && field_len != 4) return 0;
         if (month_acc < 1 || month_acc > 12) return 0;
         if (day_acc < 1 || day_acc > month_len(month_acc, year_acc)) return 0;
         return year_acc != 0;
      endfunction

      // Called for every accepted input item.
      function void note_char(logic [7:0] c, logic term);
         bit            is_digit;
         bit            good;
         int            sy, ey, sm, em, sd, ed, dd, dm, dy, pm, py;
         date_diff_type want;
         is_digit = (c >= DIGIT_0 && c <= DIGIT_9);
         if (!term) begin
            if (shape_bad) return;
            if (field_num < 2) begin
               // Day and month fields: one or two digits closed by a slash.
               if (c == SLASH_CH) begin
                  if (field_len == 1 || field_len == 2) begin
                     field_num++;
                     field_len = 0;
                  end else begin
                     shape_bad = 1;
                  end
               end else if (is_digit && field_len < 2) begin
                  if (field_num == 0) day_acc = 7'(day_acc * 10 + (c - DIGIT_0));
                  else month_acc = 7'(month_acc * 10 + (c - DIGIT_0));
                  field_len++;
               end else begin
                  shape_bad = 1;
               end
            end else begin
               // Year field: a slash counts toward the length but ends the value.
               if ((!is_digit && c != SLASH_CH) || field_len >= 4) begin
                  shape_bad = 1;
               end else begin
                  field_len++;
                  if (c == SLASH_CH) year_cut = 1;
                  else if (!year_cut) year_acc = 14'(year_acc * 10 + (c - DIGIT_0));
               end
            end
            return;
         end

         good = fields_valid();
         if (!on_end) begin
            start_good  = good;
            start_day   = day_acc;
            start_month = month_acc;
            start_year  = year_acc;
            on_end      = 1;
         end else begin
            want = '0;
            if (!start_good) begin
               want.status = STATUS_START_BAD;
            end else if (!good) begin
               want.status = STATUS_END_BAD;
            end else begin
               sy = start_year;
               ey = year_acc;
               sm = start_month;
               em = month_acc;
               sd = start_day;
               ed = day_acc;
               if (sy < 100) sy += 2000;
               if (ey < 100) ey += 2000;
               if (sy * 10000 + sm * 100 + sd > ey * 10000 + em * 100 + ed) begin
                  want.status = STATUS_ORDER;
               end else begin
                  want.status = STATUS_OK;
                  dd = ed - sd;
                  dm = em - sm;
                  dy = ey - sy;
                  if (dm < 0 || (dm == 0 && dd < 0)) begin
                     dy--;
                     dm += 12;
                  end
                  // Borrow days from the month before the end month.
                  if (dd < 0) begin
                     pm = em - 1;
                     py = ey;
                     dm--;
                     if (pm == 0) begin
                        pm = 12;
                        py--;
                     end
                     dd = month_len(pm, py) - sd + ed;
                  end
                  want.years  = dy[YEAR_W-1:0];
                  want.months = dm[MONTH_W-1:0];
                  want.days   = dd[DAYS_W-1:0];
               end
            end
            pending_diffs.push_back(want);
            on_end = 0;
         end
         clear_fields();
      endfunction

      // Called for every accepted result item.
      function void check_result(date_diff_type got);
         date_diff_type want;
         if (pending_diffs.size() == 0) begin
            $display("%0t: result item with none expected, status %0d years %0d",
                     $time, got.status, got.years);
            error_count++;
            return;
         end
         want = pending_diffs.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            error_count++;
         end
         if (got.years !== want.years) begin
            $display("%0t: years expected %0d, got %0d", $time, want.years, got.years);
            error_count++;
         end
         if (got.months !== want.months) begin
            $display("%0t: months expected %0d, got %0d", $time, want.months, got.months);
            error_count++;
         end
         if (got.days !== want.days) begin
            $display("%0t: days expected %0d, got %0d", $time, want.days, got.days);
            error_count++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_ch         = 8'd0;
   logic                      req_terminator = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [1:0]                rsp_status;
   logic [YEAR_W-1:0]         rsp_years;
   logic [MONTH_W-1:0]        rsp_months;
   logic signed [DAYS_W-1:0]  rsp_days;

   date_diff_tracker diffs = new();
   logic [7:0]       text_q[$];
   bit               tx_calm;
   bit               rx_calm;
   int               chars_sent;
   int               pair_count;

   date_string_difference dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_terminator (req_terminator),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_years      (rsp_years),
      .rsp_months     (rsp_months),
      .rsp_days       (rsp_days)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Send one item after a random gap and wait until the block takes it.
   task automatic send_item(logic [7:0] c, logic term);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ch         <= c;
      req_terminator <= term;
      do @(posedge clock); while (!req_ready);
      diffs.note_char(c, term);
      chars_sent++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // Send the queued characters as one string, closed by a terminator item
   // whose character is random.
   task automatic send_text();
      foreach (text_q[i]) send_item(text_q[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      text_q.delete();
   endtask

   task automatic send_pair(string first, string last);
      push_text(first);
      send_text();
      push_text(last);
      send_text();
   endtask

   // Hold off the input until every expected result item has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (diffs.pending_diffs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Queue one random date string: mostly well formed, some noise and some
   // with a single damaged character.
   task automatic build_date();
      int    kind;
      int    d;
      int    m;
      int    pos;
      string s;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(0, 10)) begin
            pos = $urandom_range(0, 9);
            if (pos < 5) text_q.push_back(8'(DIGIT_0 + $urandom_range(0, 9)));
            else if (pos < 8) text_q.push_back(SLASH_CH);
            else text_q.push_back(8'($urandom_range(0, 255)));
         end
         return;
      end
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 39);
      else d = $urandom_range(1, 31);
      if ($urandom_range(0, 19) == 0) m = $urandom_range(0, 15);
      else m = $urandom_range(1, 12);
      s = (d < 10 && $urandom_range(0, 1)) ? $sformatf("%0d", d) : $sformatf("%02d", d);
      push_text(s);
      text_q.push_back(SLASH_CH);
      s = (m < 10 && $urandom_range(0, 1)) ? $sformatf("%0d", m) : $sformatf("%02d", m);
      push_text(s);
      text_q.push_back(SLASH_CH);

      // Years mostly from a narrow window so that both orders occur.
      pos = $urandom_range(0, 9);
      if (pos < 5) s = $sformatf("%02d", $urandom_range(15, 30));
      else if (pos < 8) s = $sformatf("%04d", $urandom_range(2015, 2030));
      else if (pos == 8) s = $sformatf("%04d", $urandom_range(0, 9999));
      else s = $sformatf("%02d", $urandom_range(0, 99));
      if ($urandom_range(0, 19) == 0) s.putc($urandom_range(0, s.len() - 1), "/");
      push_text(s);

      if (kind >= 90) begin
         pos = $urandom_range(0, text_q.size() - 1);
         case ($urandom_range(0, 2))
            0: text_q[pos] = 8'($urandom_range(0, 255));
            1: text_q.delete(pos);
            default: text_q.insert(pos, $urandom_range(0, 1) ? SLASH_CH
                                        : 8'(DIGIT_0 + $urandom_range(0, 9)));
         endcase
      end
   endtask

   // Result side: take each result item, then stall for a random time.
   initial begin
      date_diff_type got;
      int            stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_years, rsp_months, rsp_days};
            diffs.check_result(got);
            stall = rx_calm ? 0 : $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main sequence.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Equal dates, negative day borrow, leap borrow, year wrap, widest span.
      send_pair("01/01/2000", "01/01/2000");
      send_pair("31/01/2023", "01/03/2023");
      send_pair("31/01/24", "01/03/24");
      send_pair("15/12/2020", "10/01/2021");
      send_pair("01/01/0100", "31/12/9999");
      send_pair("5/6/99", "05/06/2099");
      // Start after end, bad leap days, leap rule on a two-digit year.
      send_pair("29/02/2024", "28/02/2024");
      send_pair("29/02/2023", "1/1/23");
      send_pair("29/02/1900", "1/1/2000");
      send_pair("29/02/04", "1/3/2004");
      send_pair("31/04/2021", "1/5/2021");
      // Month, day and year out of range.
      send_pair("1/13/20", "1/1/21");
      send_pair("0/1/20", "1/1/21");
      send_pair("1/1/00", "1/1/21");
      // A slash inside the year, and a year that starts with one.
      send_pair("1/1/2/34", "1/1/2002");
      send_pair("1/1/20", "1/1//999");
      // Early terminator, empty string and malformed shapes.
      send_pair("12/05", "");
      send_pair("1/1/20", "12/05");
      send_pair("123/1/20", "1/1/20");
      send_pair("1/1/20", "/1/20");
      send_pair("1/1/20", "1/1/202");
      send_pair("1/1/2020", "1/1/20201");
      send_pair("1a/1/20", "1/1/20");
      // Characters at both ends of the byte range.
      push_text("1/1/20");
      text_q.push_back(8'hFF);
      push_text("9");
      send_text();
      push_text("1/1/20");
      text_q.push_back(8'h00);
      send_text();
      wait_for_results();

      // Random date pairs with changing idle behavior on both sides, until
      // the whole run has sent its share of items.
      pair_count = 0;
      while (chars_sent < RANDOM_CHARS || pair_count < RANDOM_PAIRS) begin
         if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
         if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
         build_date();
         send_text();
         build_date();
         send_text();
         pair_count++;
         if ($urandom_range(0, 19) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (diffs.error_count == 0 && diffs.pending_diffs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
